// File: hdl/pfi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfi_pkg
// Shared constants, codes and lane command/status types of the pan fling
// inertia unit.
// ----------------------------------------------------------------------------
package pfi_pkg;

    // coast tick length in milliseconds
    localparam logic [7:0] TICK_MS   = 8'd30;
    localparam int         NUM_LANES = 2;
    localparam int         BUDGET_W  = 14;
    localparam int         DIV_W     = 48;
    localparam int         DVS_W     = 33;

    // function selector codes
    localparam logic [2:0] FN_OBSERVE = 3'd0;
    localparam logic [2:0] FN_START   = 3'd1;
    localparam logic [2:0] FN_ADVANCE = 3'd2;
    localparam logic [2:0] FN_CANCEL  = 3'd3;
    localparam logic [2:0] FN_RESET   = 3'd4;

    // configuration register indexes
    localparam logic [3:0] REG_COMBINE  = 4'd0;
    localparam logic [3:0] REG_HIST_GAP = 4'd1;
    localparam logic [3:0] REG_REL_IDLE = 4'd2;
    localparam logic [3:0] REG_START_SP = 4'd3;
    localparam logic [3:0] REG_MAX_SP   = 4'd4;
    localparam logic [3:0] REG_STOP_SP  = 4'd5;
    localparam logic [3:0] REG_DECAY    = 4'd6;
    localparam logic [3:0] REG_MAX_TICK = 4'd7;

    // lane operation codes
    localparam logic [3:0] LOP_NONE      = 4'd0;
    localparam logic [3:0] LOP_OBS_CLR   = 4'd1;
    localparam logic [3:0] LOP_OBS_ACC   = 4'd2;
    localparam logic [3:0] LOP_OBS_DIV   = 4'd3;
    localparam logic [3:0] LOP_VEL_SET   = 4'd4;
    localparam logic [3:0] LOP_VEL_BLEND = 4'd5;
    localparam logic [3:0] LOP_CANCEL    = 4'd6;
    localparam logic [3:0] LOP_RESET     = 4'd7;
    localparam logic [3:0] LOP_START     = 4'd8;
    localparam logic [3:0] LOP_SCALE     = 4'd9;
    localparam logic [3:0] LOP_SCALE_SET = 4'd10;
    localparam logic [3:0] LOP_TICK      = 4'd11;
    localparam logic [3:0] LOP_FINISH    = 4'd12;

    typedef struct packed {
        logic [3:0] op;
        logic       ld_pos;
    } lane_cmd_t;

    typedef struct packed {
        logic busy;
        logic moved;
        logic last_same;
    } lane_stat_t;

endpackage

// File: hdl/pfi_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfi_lane
// One axis of the fling engine: position history, velocity, tick
// remainder, a restoring divider and the per-tick position and decay step.
// ----------------------------------------------------------------------------
module pfi_lane
    import pfi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lane_cmd_t                cmd,
    input  logic signed [31:0]       pos_in,
    input  logic [DVS_W-1:0]         divisor,
    input  logic [15:0]              max_speed,
    input  logic [7:0]               decay,
    output lane_stat_t               stat,
    output logic signed [31:0]       vel,
    output logic signed [31:0]       pos_out
);

    logic signed [31:0] last_reg, last_next;
    logic signed [31:0] sample_reg, sample_next;
    logic signed [31:0] vel_reg, vel_next;
    logic signed [8:0]  frac_reg, frac_next;
    logic signed [31:0] acc_reg, acc_next;
    logic               moved_reg, moved_next;
    logic [DIV_W-1:0]   dq_reg, dq_next;
    logic [DVS_W-1:0]   rem_reg, rem_next;
    logic [DVS_W-1:0]   dvs_reg, dvs_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               neg_reg, neg_next;

    // observe numerator: |pos - sample| * TICK_MS * 256
    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    logic [DIV_W-1:0]   obs_num;
    logic [31:0]        vel_mag;
    logic [DIV_W-1:0]   scale_num;

    assign diff     = {pos_in[31], pos_in} - {sample_reg[31], sample_reg};
    assign diff_mag = diff[32] ? (33'd0 - diff) : diff;
    assign obs_num  = DIV_W'(diff_mag) * DIV_W'({TICK_MS, 8'd0});
    assign vel_mag  = vel_reg[31] ? (32'd0 - vel_reg) : vel_reg;
    assign scale_num = DIV_W'(vel_mag) * DIV_W'(max_speed);

    // divider step
    logic [DVS_W:0] rem_sh;
    logic           rem_ge;
    assign rem_sh = {rem_reg, dq_reg[DIV_W-1]};
    assign rem_ge = rem_sh >= {1'b0, dvs_reg};

    // signed quotient clamped to 32 bits
    logic        pos_ovf, neg_ovf;
    logic [31:0] q_val;
    assign pos_ovf = |dq_reg[DIV_W-1:31];
    assign neg_ovf = (|dq_reg[DIV_W-1:32]) || (dq_reg[31] && (|dq_reg[30:0]));
    always_comb
    begin
        if (neg_reg)
            q_val = neg_ovf ? 32'h8000_0000 : (32'd0 - dq_reg[31:0]);
        else
            q_val = pos_ovf ? 32'h7FFF_FFFF : dq_reg[31:0];
    end

    // quarter-old, three-quarter-new blend, truncated toward zero
    logic signed [34:0] bl_sum, bl_b, bl_sh;
    assign bl_sum = {{3{vel_reg[31]}}, vel_reg} + {{2{q_val[31]}}, q_val, 1'b0}
                  + {{3{q_val[31]}}, q_val};
    assign bl_b   = bl_sum[34] ? (bl_sum + 35'sd3) : bl_sum;
    assign bl_sh  = bl_b >>> 2;

    // tick: whole pixels out of velocity plus remainder
    logic signed [32:0] tk_a, tk_b, tk_q, tk_rem;
    logic signed [33:0] tk_sum;
    logic signed [31:0] tk_pos;
    assign tk_a   = {{24{frac_reg[8]}}, frac_reg} + {vel_reg[31], vel_reg};
    assign tk_b   = tk_a[32] ? (tk_a + 33'sd255) : tk_a;
    assign tk_q   = tk_b >>> 8;
    assign tk_rem = tk_a - (tk_q <<< 8);
    assign tk_sum = {tk_q[32], tk_q} + {{2{acc_reg[31]}}, acc_reg};
    always_comb
    begin
        if (tk_sum[33:31] == 3'b000 || tk_sum[33:31] == 3'b111)
            tk_pos = tk_sum[31:0];
        else if (tk_sum[33])
            tk_pos = 32'sh8000_0000;
        else
            tk_pos = 32'sh7FFF_FFFF;
    end

    // velocity decay, truncated toward zero
    logic signed [40:0] tk_p, tk_pb, tk_ps;
    assign tk_p  = 41'(vel_reg) * 41'($signed({1'b0, decay}));
    assign tk_pb = tk_p[40] ? (tk_p + 41'sd255) : tk_p;
    assign tk_ps = tk_pb >>> 8;

    // next state
    always_comb
    begin
        last_next   = last_reg;
        sample_next = sample_reg;
        vel_next    = vel_reg;
        frac_next   = frac_reg;
        acc_next    = acc_reg;
        moved_next  = moved_reg;
        dq_next     = dq_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        neg_next    = neg_reg;

        if (busy_reg)
        begin
            dq_next  = {dq_reg[DIV_W-2:0], rem_ge};
            rem_next = rem_ge ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVS_W-1:0];
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
                busy_next = 1'b0;
        end

        if (cmd.ld_pos)
        begin
            acc_next   = pos_in;
            moved_next = 1'b0;
        end

        case (cmd.op)
            LOP_OBS_CLR:
            begin
                last_next   = pos_in;
                sample_next = pos_in;
                vel_next    = '0;
            end
            LOP_OBS_ACC:
                last_next = pos_in;
            LOP_OBS_DIV:
            begin
                last_next   = pos_in;
                sample_next = pos_in;
                dq_next     = obs_num;
                rem_next    = '0;
                dvs_next    = divisor;
                cnt_next    = 6'(DIV_W - 1);
                busy_next   = 1'b1;
                neg_next    = diff[32];
            end
            LOP_VEL_SET:
                vel_next = q_val;
            LOP_VEL_BLEND:
                vel_next = bl_sh[31:0];
            LOP_CANCEL:
            begin
                sample_next = last_reg;
                vel_next    = '0;
                frac_next   = '0;
            end
            LOP_RESET:
            begin
                last_next   = pos_in;
                sample_next = pos_in;
                vel_next    = '0;
                frac_next   = '0;
            end
            LOP_START:
            begin
                sample_next = last_reg;
                frac_next   = '0;
            end
            LOP_SCALE:
            begin
                sample_next = last_reg;
                frac_next   = '0;
                dq_next     = scale_num;
                rem_next    = '0;
                dvs_next    = divisor;
                cnt_next    = 6'(DIV_W - 1);
                busy_next   = 1'b1;
                neg_next    = vel_reg[31];
            end
            LOP_SCALE_SET:
                vel_next = q_val;
            LOP_TICK:
            begin
                acc_next  = tk_pos;
                frac_next = tk_rem[8:0];
                vel_next  = tk_ps[31:0];
                if (tk_pos != acc_reg)
                    moved_next = 1'b1;
            end
            LOP_FINISH:
            begin
                vel_next  = '0;
                frac_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= '0;
            sample_reg <= '0;
            vel_reg    <= '0;
            frac_reg   <= '0;
            moved_reg  <= 1'b0;
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            last_reg   <= last_next;
            sample_reg <= sample_next;
            vel_reg    <= vel_next;
            frac_reg   <= frac_next;
            moved_reg  <= moved_next;
            cnt_reg    <= cnt_next;
            busy_reg   <= busy_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign stat.busy      = busy_reg;
    assign stat.moved     = moved_reg;
    assign stat.last_same = (pos_in == last_reg);
    assign vel            = vel_reg;
    assign pos_out        = acc_reg;

endmodule

// File: hdl/pan_fling_inertia_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pan_fling_inertia_unit
// Kinetic scroll inertia: velocity tracking, fling start and coasting for a
// panned viewport, with one lane per axis and a shared speed/control stage.
// ----------------------------------------------------------------------------
// Usage:
// - input beats on s_axis: tuser carries the function (observe, start,
//   advance, cancel, reset), tdata the position and elapsed milliseconds
// - one result beat on m_axis per input beat, in order
// - cfg channel writes one register per beat; cfg_ready is always high
// Sequence, from acceptance to result in the output register:
// - observe without a sample, cancel, reset, idle advance: decode, then done
// - observe with a sample, or a start that hits the speed cap: decode, then a
//   wait on the 48-step restoring divider in each lane, then done
// - advance: decode, then the loop, speed and check states per coast tick (up to 63 ticks), then done
// One beat is in flight at a time; s_axis_tready is high while waiting.
// Reset clears the control state and loads register defaults; datapath registers are not reset. A stalled receiver
// holds the result in the output register; the next beat may be accepted
// but its result waits until the register is free.
// ----------------------------------------------------------------------------
module pan_fling_inertia_unit
    import pfi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input beat
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // pos_x, pos_y, delta_ms
    input  logic [2:0]  s_axis_tuser,   // func
    // result beat
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // new_x, new_y, moved, fling_started, coasting, zero pad
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_LOOP   = 3'd3;
    localparam logic [2:0] ST_SPD    = 3'd4;
    localparam logic [2:0] ST_CHK    = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    localparam logic [1:0] DK_SET   = 2'd0;
    localparam logic [1:0] DK_BLEND = 2'd1;
    localparam logic [1:0] DK_SCALE = 2'd2;

    // configuration registers
    logic [7:0]  combine_reg, gap_reg, rel_idle_reg, decay_reg;
    logic [15:0] start_sp_reg, max_sp_reg, stop_sp_reg;
    logic [5:0]  max_ticks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            combine_reg   <= 8'd8;
            gap_reg       <= 8'd120;
            rel_idle_reg  <= 8'd80;
            start_sp_reg  <= 16'd512;
            max_sp_reg    <= 16'd3584;
            stop_sp_reg   <= 16'd128;
            decay_reg     <= 8'd208;
            max_ticks_reg <= 6'd12;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_COMBINE:  combine_reg   <= cfg_data[7:0];
                REG_HIST_GAP: gap_reg       <= cfg_data[7:0];
                REG_REL_IDLE: rel_idle_reg  <= cfg_data[7:0];
                REG_START_SP: start_sp_reg  <= cfg_data;
                REG_MAX_SP:   max_sp_reg    <= cfg_data;
                REG_STOP_SP:  stop_sp_reg   <= cfg_data;
                REG_DECAY:    decay_reg     <= cfg_data[7:0];
                REG_MAX_TICK: max_ticks_reg <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    // control state
    logic [2:0]          state_reg, state_next;
    logic [2:0]          func_reg, func_next;
    logic signed [31:0]  pos_reg [NUM_LANES];
    logic [31:0]         dt_reg;
    logic [7:0]          window_reg, window_next;
    logic [7:0]          idle_reg, idle_next;
    logic                valid_reg, valid_next;
    logic                coast_reg, coast_next;
    logic [7:0]          phase_reg, phase_next;
    logic [5:0]          ticks_reg, ticks_next;
    logic [BUDGET_W-1:0] budget_reg, budget_next;
    logic [1:0]          kind_reg, kind_next;
    logic                started_reg, started_next;
    logic [32:0]         speed_reg;
    logic                out_valid_reg;
    logic [66:0]         out_data_reg;

    logic                in_fire;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // lanes
    lane_cmd_t           cmd;
    lane_stat_t          stat [NUM_LANES];
    logic signed [31:0]  lane_vel [NUM_LANES];
    logic signed [31:0]  lane_pos [NUM_LANES];
    logic [DVS_W-1:0]    divisor;

    genvar g;
    generate
        for (g = 0; g < NUM_LANES; g++)
        begin : g_lane
            pfi_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .pos_in    (pos_reg[g]),
                .divisor   (divisor),
                .max_speed (max_sp_reg),
                .decay     (decay_reg),
                .stat      (stat[g]),
                .vel       (lane_vel[g]),
                .pos_out   (lane_pos[g])
            );
        end
    endgenerate

    // merge: approximate speed max + min/2, registered
    logic [31:0] mag_x, mag_y, sp_hi, sp_lo;
    assign mag_x = lane_vel[0][31] ? (32'd0 - lane_vel[0]) : lane_vel[0];
    assign mag_y = lane_vel[1][31] ? (32'd0 - lane_vel[1]) : lane_vel[1];
    assign sp_hi = (mag_x > mag_y) ? mag_x : mag_y;
    assign sp_lo = (mag_x > mag_y) ? mag_y : mag_x;

    always_ff @(posedge clk)
    begin
        speed_reg <= {1'b0, sp_hi} + {2'b0, sp_lo[31:1]};
    end

    // observe helpers
    logic [8:0]  idle_cap9;
    logic [7:0]  idle_cap, comb_eff;
    logic [8:0]  win_total;
    logic        pos_changed;
    assign idle_cap9   = {1'b0, rel_idle_reg} + 9'd1;
    assign idle_cap    = idle_cap9[8] ? 8'd255 : idle_cap9[7:0];
    assign comb_eff    = (combine_reg == 8'd0) ? 8'd1 : combine_reg;
    assign win_total   = {1'b0, window_reg} + {1'b0, dt_reg[7:0]};
    assign pos_changed = !(stat[0].last_same && stat[1].last_same);

    // advance helpers
    logic [5:0]          remaining;
    logic [BUDGET_W-1:0] rem_ms, to_finish;
    logic [5:0]          tick_inc;
    assign remaining = (ticks_reg < max_ticks_reg) ? (max_ticks_reg - ticks_reg) : 6'd1;
    assign rem_ms    = BUDGET_W'(remaining) * BUDGET_W'(TICK_MS);
    assign to_finish = rem_ms - BUDGET_W'(phase_reg);
    assign tick_inc  = ticks_reg + 6'd1;

    assign divisor = (kind_reg == DK_SCALE || func_reg == FN_START) ?
                     speed_reg : DVS_W'(win_total);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        window_next  = window_reg;
        idle_next    = idle_reg;
        valid_next   = valid_reg;
        coast_next   = coast_reg;
        phase_next   = phase_reg;
        ticks_next   = ticks_reg;
        budget_next  = budget_reg;
        kind_next    = kind_reg;
        started_next = started_reg;
        cmd.op       = LOP_NONE;
        cmd.ld_pos   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    func_next = s_axis_tuser;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.ld_pos   = 1'b1;
                started_next = 1'b0;
                state_next   = ST_DONE;
                case (func_reg)
                    FN_OBSERVE:
                    begin
                        if (pos_changed)
                            idle_next = 8'd0;
                        else if (idle_reg >= idle_cap ||
                                 dt_reg >= 32'(idle_cap - idle_reg))
                            idle_next = idle_cap;
                        else
                            idle_next = idle_reg + dt_reg[7:0];
                        if (dt_reg > 32'(gap_reg))
                        begin
                            cmd.op      = LOP_OBS_CLR;
                            window_next = 8'd0;
                            valid_next  = 1'b0;
                        end
                        else if (win_total < {1'b0, comb_eff})
                        begin
                            cmd.op      = LOP_OBS_ACC;
                            window_next = win_total[7:0];
                        end
                        else
                        begin
                            cmd.op      = LOP_OBS_DIV;
                            window_next = 8'd0;
                            kind_next   = valid_reg ? DK_BLEND : DK_SET;
                            state_next  = ST_DIV;
                        end
                    end
                    FN_START:
                    begin
                        if (!valid_reg || idle_reg > rel_idle_reg ||
                            speed_reg < {17'd0, start_sp_reg})
                        begin
                            cmd.op      = LOP_CANCEL;
                            valid_next  = 1'b0;
                            window_next = 8'd0;
                            idle_next   = 8'd0;
                            phase_next  = 8'd0;
                            ticks_next  = 6'd0;
                            coast_next  = 1'b0;
                        end
                        else
                        begin
                            started_next = 1'b1;
                            window_next  = 8'd0;
                            phase_next   = 8'd0;
                            ticks_next   = 6'd0;
                            coast_next   = 1'b1;
                            if (speed_reg > {17'd0, max_sp_reg})
                            begin
                                cmd.op     = LOP_SCALE;
                                kind_next  = DK_SCALE;
                                state_next = ST_DIV;
                            end
                            else
                                cmd.op = LOP_START;
                        end
                    end
                    FN_ADVANCE:
                    begin
                        if (coast_reg)
                        begin
                            if (dt_reg >= 32'(to_finish))
                                budget_next = rem_ms;
                            else
                                budget_next = BUDGET_W'(phase_reg) + dt_reg[BUDGET_W-1:0];
                            state_next = ST_LOOP;
                        end
                    end
                    FN_CANCEL:
                    begin
                        cmd.op      = LOP_CANCEL;
                        valid_next  = 1'b0;
                        window_next = 8'd0;
                        idle_next   = 8'd0;
                        phase_next  = 8'd0;
                        ticks_next  = 6'd0;
                        coast_next  = 1'b0;
                    end
                    FN_RESET:
                    begin
                        cmd.op      = LOP_RESET;
                        valid_next  = 1'b0;
                        window_next = 8'd0;
                        idle_next   = 8'd0;
                        phase_next  = 8'd0;
                        ticks_next  = 6'd0;
                        coast_next  = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_DIV:
            begin
                if (!stat[0].busy && !stat[1].busy)
                begin
                    unique case (kind_reg)
                        DK_SET:   cmd.op = LOP_VEL_SET;
                        DK_BLEND: cmd.op = LOP_VEL_BLEND;
                        default:  cmd.op = LOP_SCALE_SET;
                    endcase
                    if (kind_reg != DK_SCALE)
                        valid_next = 1'b1;
                    kind_next  = DK_SET;
                    state_next = ST_DONE;
                end
            end
            ST_LOOP:
            begin
                if (coast_reg && budget_reg >= BUDGET_W'(TICK_MS))
                begin
                    cmd.op      = LOP_TICK;
                    budget_next = budget_reg - BUDGET_W'(TICK_MS);
                    state_next  = ST_SPD;
                end
                else
                begin
                    if (coast_reg)
                        phase_next = budget_reg[7:0];
                    state_next = ST_DONE;
                end
            end
            ST_SPD:
                state_next = ST_CHK;
            ST_CHK:
            begin
                ticks_next = tick_inc;
                if (tick_inc >= max_ticks_reg || speed_reg < {17'd0, stop_sp_reg})
                begin
                    cmd.op     = LOP_FINISH;
                    coast_next = 1'b0;
                    phase_next = 8'd0;
                    valid_next = 1'b0;
                end
                state_next = ST_LOOP;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            func_reg    <= FN_OBSERVE;
            window_reg  <= '0;
            idle_reg    <= '0;
            valid_reg   <= 1'b0;
            coast_reg   <= 1'b0;
            phase_reg   <= '0;
            ticks_reg   <= '0;
            budget_reg  <= '0;
            kind_reg    <= DK_SET;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            func_reg    <= func_next;
            window_reg  <= window_next;
            idle_reg    <= idle_next;
            valid_reg   <= valid_next;
            coast_reg   <= coast_next;
            phase_reg   <= phase_next;
            ticks_reg   <= ticks_next;
            budget_reg  <= budget_next;
            kind_reg    <= kind_next;
            started_reg <= started_next;
        end
    end

    // input payload capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pos_reg[0] <= s_axis_tdata[31:0];
            pos_reg[1] <= s_axis_tdata[63:32];
            dt_reg     <= s_axis_tdata[95:64];
        end
    end

    // output register
    logic out_load;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= {coast_reg, started_reg, stat[0].moved | stat[1].moved,
                             lane_pos[1], lane_pos[0]};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_data_reg};

endmodule

// File: hdl/pfi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfi_checker
// Port-level assertions for the pan fling inertia unit, bound to the top.
// ----------------------------------------------------------------------------
module pfi_checker
    import pfi_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // a started fling is coasting
    a_start_coast: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[65] || m_axis_tdata[66])
        else $error("fling started without coasting");

    // moved and started never in the same result
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[64] && m_axis_tdata[65]))
        else $error("moved and started both set");

    // pad bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[71:67] == 5'd0)
        else $error("result pad bits nonzero");

    // no new beat taken in the cycle after one was taken
    a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat accepted back to back");

endmodule

bind pan_fling_inertia_unit pfi_checker u_pfi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/pan_fling_inertia_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pan_fling_inertia_unit_tb
// Self-checking bench for the pan fling inertia unit. A queue-fed driver
// sends function beats, a behavioral predictor computes the expected result
// of each accepted beat, and a monitor compares every result beat field by
// field. Runs a directed set, then random gestures and noise under several
// register settings, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module pan_fling_inertia_unit_tb;
    import pfi_pkg::*;

    typedef struct {
        logic [2:0]         fn;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [31:0]        dt;
    } gesture_beat_t;

    typedef struct {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic               moved;
        logic               started;
        logic               coast;
    } view_result_t;

    localparam longint TICK = 30;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [15:0] cfg_data;

    gesture_beat_t pending_beats[$];
    view_result_t  expected_views[$];
    int            mismatches;
    int            send_gap;
    int            recv_gap;
    int            hold_cnt;
    bit            hold_armed;
    bit            hold_used;
    bit            quiet_mode;
    int            sent_cnt = 0;
    int            taken_cnt = 0;

    // predictor registers and state
    longint r_combine, r_hist, r_idle, r_start, r_max, r_stop, r_decay, r_ticks;
    longint m_last_x, m_last_y, m_samp_x, m_samp_y;
    longint m_window, m_idle, m_phase, m_done;
    longint m_vx, m_vy, m_fx, m_fy;
    bit     m_vvalid, m_coast;

    pan_fling_inertia_unit dut (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #40ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint approx_speed(longint a, longint b);
        longint ma, mb;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        return (ma > mb) ? ma + mb / 2 : mb + ma / 2;
    endfunction

    function automatic void drop_history();
        m_samp_x = m_last_x;
        m_samp_y = m_last_y;
        m_window = 0;
        m_vx = 0;
        m_vy = 0;
        m_vvalid = 0;
    endfunction

    function automatic void drop_fling();
        drop_history();
        m_idle = 0;
        m_phase = 0;
        m_done = 0;
        m_fx = 0;
        m_fy = 0;
        m_coast = 0;
    endfunction

    function automatic void end_coast();
        m_coast = 0;
        m_phase = 0;
        m_vx = 0;
        m_vy = 0;
        m_fx = 0;
        m_fy = 0;
        m_vvalid = 0;
    endfunction

    task automatic load_register(logic [3:0] idx, logic [15:0] val);
        case (idx)
            REG_COMBINE:  r_combine = val[7:0];
            REG_HIST_GAP: r_hist = val[7:0];
            REG_REL_IDLE: r_idle = val[7:0];
            REG_START_SP: r_start = val;
            REG_MAX_SP:   r_max = val;
            REG_STOP_SP:  r_stop = val;
            REG_DECAY:    r_decay = val[7:0];
            REG_MAX_TICK: r_ticks = val[5:0];
            default: ;
        endcase
    endtask

    task automatic clear_fling_state();
        r_combine = 8; r_hist = 120; r_idle = 80; r_start = 512;
        r_max = 3584; r_stop = 128; r_decay = 208; r_ticks = 12;
        m_last_x = 0; m_last_y = 0; m_samp_x = 0; m_samp_y = 0;
        m_window = 0; m_idle = 0; m_phase = 0; m_done = 0;
        m_vx = 0; m_vy = 0; m_fx = 0; m_fy = 0;
        m_vvalid = 0; m_coast = 0;
    endtask

    // expected result of one beat, updating the predictor state
    function automatic view_result_t predict_fling(gesture_beat_t b);
        view_result_t res;
        longint x, y, dt, cap, comb, total, nx, ny, ax, ay, spd, remaining, ready;
        x = b.px;
        y = b.py;
        dt = longint'(b.dt);
        res.moved = 0;
        res.started = 0;
        case (b.fn)
            FN_OBSERVE:
            begin
                cap = (r_idle + 1 > 255) ? 255 : r_idle + 1;
                comb = (r_combine == 0) ? 1 : r_combine;
                if (x != m_last_x || y != m_last_y)
                    m_idle = 0;
                else if (m_idle >= cap || dt >= cap - m_idle)
                    m_idle = cap;
                else
                    m_idle += dt;
                m_last_x = x;
                m_last_y = y;
                if (dt > r_hist)
                    drop_history();
                else
                begin
                    total = m_window + dt;
                    if (total < comb)
                        m_window = total;
                    else
                    begin
                        nx = sat32((x - m_samp_x) * TICK * 256 / total);
                        ny = sat32((y - m_samp_y) * TICK * 256 / total);
                        m_samp_x = x;
                        m_samp_y = y;
                        m_window = 0;
                        if (m_vvalid)
                        begin
                            m_vx = (m_vx + nx * 3) / 4;
                            m_vy = (m_vy + ny * 3) / 4;
                        end
                        else
                        begin
                            m_vx = nx;
                            m_vy = ny;
                            m_vvalid = 1;
                        end
                    end
                end
            end
            FN_START:
            begin
                spd = approx_speed(m_vx, m_vy);
                if (!m_vvalid || m_idle > r_idle || spd < r_start)
                    drop_fling();
                else
                begin
                    if (spd > r_max)
                    begin
                        m_vx = m_vx * r_max / spd;
                        m_vy = m_vy * r_max / spd;
                    end
                    m_samp_x = m_last_x;
                    m_samp_y = m_last_y;
                    m_window = 0;
                    m_phase = 0;
                    m_done = 0;
                    m_fx = 0;
                    m_fy = 0;
                    m_coast = 1;
                    res.started = 1;
                end
            end
            FN_ADVANCE:
            begin
                if (m_coast)
                begin
                    remaining = (m_done < r_ticks) ? r_ticks - m_done : 1;
                    if (dt >= remaining * TICK - m_phase)
                    begin
                        ready = remaining;
                        m_phase = 0;
                    end
                    else
                    begin
                        total = m_phase + dt;
                        ready = total / TICK;
                        m_phase = total - ready * TICK;
                    end
                    while (ready > 0 && m_coast)
                    begin
                        ax = m_fx + m_vx;
                        ay = m_fy + m_vy;
                        nx = sat32(x + ax / 256);
                        ny = sat32(y + ay / 256);
                        ready--;
                        m_fx = ax % 256;
                        m_fy = ay % 256;
                        if (nx != x || ny != y)
                            res.moved = 1;
                        x = nx;
                        y = ny;
                        m_vx = m_vx * r_decay / 256;
                        m_vy = m_vy * r_decay / 256;
                        m_done = (m_done + 1) & 63;
                        if (m_done >= r_ticks || approx_speed(m_vx, m_vy) < r_stop)
                            end_coast();
                    end
                end
            end
            FN_CANCEL:
                drop_fling();
            FN_RESET:
            begin
                m_last_x = x; m_samp_x = x;
                m_last_y = y; m_samp_y = y;
                m_window = 0; m_idle = 0; m_phase = 0; m_done = 0;
                m_vx = 0; m_vy = 0; m_fx = 0; m_fy = 0;
                m_vvalid = 0; m_coast = 0;
            end
            default: ;
        endcase
        res.nx = x[31:0];
        res.ny = y[31:0];
        res.coast = m_coast;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // accept side: predict on input beats, check result beats, track cfg writes
    always @(posedge clk)
    begin
        gesture_beat_t b;
        view_result_t  want;
        if (rst_n && cfg_valid && cfg_ready)
            load_register(cfg_index, cfg_data);
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            b.fn = s_axis_tuser;
            b.px = s_axis_tdata[31:0];
            b.py = s_axis_tdata[63:32];
            b.dt = s_axis_tdata[95:64];
            expected_views.push_back(predict_fling(b));
            void'(pending_beats.pop_front());
            taken_cnt++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_views.size() == 0)
                report_mismatch("unexpected beat", 0, 0);
            else
            begin
                want = expected_views.pop_front();
                if ($signed(m_axis_tdata[31:0]) != want.nx)
                    report_mismatch("new_x", $signed(m_axis_tdata[31:0]), want.nx);
                if ($signed(m_axis_tdata[63:32]) != want.ny)
                    report_mismatch("new_y", $signed(m_axis_tdata[63:32]), want.ny);
                if (m_axis_tdata[64] != want.moved)
                    report_mismatch("moved", m_axis_tdata[64], want.moved);
                if (m_axis_tdata[65] != want.started)
                    report_mismatch("fling_started", m_axis_tdata[65], want.started);
                if (m_axis_tdata[66] != want.coast)
                    report_mismatch("coasting", m_axis_tdata[66], want.coast);
            end
        end
    end

    // input driver; a beat stays on the bus until it has been taken
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (send_gap > 0 && !s_axis_tvalid)
            send_gap <= send_gap - 1;
        else if (s_axis_tvalid && taken_cnt != sent_cnt)
            ;
        else if (pending_beats.size() > 0 && (!s_axis_tvalid || pick_gap() == 0))
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= pending_beats[0].fn;
            s_axis_tdata  <= {pending_beats[0].dt, pending_beats[0].py, pending_beats[0].px};
            sent_cnt      <= sent_cnt + 1;
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
            send_gap <= pick_gap();
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge clk)
    begin
        if (hold_armed && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_cnt <= 700;
            m_axis_tready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            recv_gap <= pick_gap();
        end
    end

    task automatic push_beat(logic [2:0] fn, logic [31:0] px, logic [31:0] py,
                             logic [31:0] dt);
        gesture_beat_t b;
        b.fn = fn;
        b.px = px;
        b.py = py;
        b.dt = dt;
        pending_beats.push_back(b);
    endtask

    task automatic write_register(logic [3:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || expected_views.size() > 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    // one drag gesture, release, then coasting with a few advances
    task automatic drag_and_fling();
        longint bx, by, sx, sy;
        int     n;
        bx = $urandom_range(0, 9) == 0 ? 64'sd2147480000 : $signed($urandom()) / 4;
        by = $urandom_range(0, 9) == 0 ? -64'sd2147480000 : $signed($urandom()) / 4;
        sx = $signed($urandom_range(0, 6000)) - 3000;
        sy = $signed($urandom_range(0, 6000)) - 3000;
        if (bx > 64'sd2000000000) sx = (sx < 0) ? -sx : sx;
        if (by < -64'sd2000000000) sy = (sy > 0) ? -sy : sy;
        if ($urandom_range(0, 3) == 0)
        begin
            sx = sx / 40;
            sy = sy / 40;
        end
        push_beat(FN_RESET, bx[31:0], by[31:0], $urandom());
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            bx = sat32(bx + sx + $signed($urandom_range(0, 20)) - 10);
            by = sat32(by + sy + $signed($urandom_range(0, 20)) - 10);
            push_beat(FN_OBSERVE, bx[31:0], by[31:0], $urandom_range(0, 25));
        end
        if ($urandom_range(0, 3) == 0)
            push_beat(FN_OBSERVE, bx[31:0], by[31:0], $urandom_range(0, 150));
        push_beat(FN_START, $urandom(), $urandom(), $urandom());
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            if ($urandom_range(0, 15) == 0)
                push_beat(FN_CANCEL, bx[31:0], by[31:0], $urandom());
            else if ($urandom_range(0, 7) == 0)
                push_beat(FN_OBSERVE, bx[31:0], by[31:0], $urandom_range(0, 40));
            else
                push_beat(FN_ADVANCE, bx[31:0], by[31:0],
                          $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 200));
        end
    endtask

    // random but mostly plausible register set, with extremes now and then
    task automatic random_settings(bit extreme_hi);
        write_register(REG_COMBINE,  extreme_hi ? 16'd255 : 16'($urandom_range(0, 40)));
        write_register(REG_HIST_GAP, extreme_hi ? 16'd255 : 16'($urandom_range(0, 200)));
        write_register(REG_REL_IDLE, extreme_hi ? 16'd255 : 16'($urandom_range(0, 120)));
        write_register(REG_START_SP, extreme_hi ? 16'hffff : 16'($urandom_range(0, 2000)));
        write_register(REG_MAX_SP,   extreme_hi ? 16'hffff : 16'($urandom_range(1, 8000)));
        write_register(REG_STOP_SP,  extreme_hi ? 16'hffff : 16'($urandom_range(0, 600)));
        write_register(REG_DECAY,    extreme_hi ? 16'd255 : 16'($urandom_range(0, 255)));
        write_register(REG_MAX_TICK, extreme_hi ? 16'd63 : 16'($urandom_range(0, 63)));
    endtask

    task automatic random_phase(int count);
        int start_sz;
        start_sz = pending_beats.size();
        while (pending_beats.size() - start_sz < count)
        begin
            if ($urandom_range(0, 4) != 0)
                drag_and_fling();
            else
                push_beat(3'($urandom_range(0, 7)), $urandom(), $urandom(), $urandom());
        end
    endtask

    // stimulus
    initial
    begin
        int ph;
        mismatches = 0;
        send_gap = 0;
        recv_gap = 0;
        hold_cnt = 0;
        hold_armed = 0;
        hold_used = 0;
        quiet_mode = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        clear_fling_state();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: idle advance, refused start, unused selectors, field extremes
        push_beat(FN_ADVANCE, 32'h7fffffff, 32'h80000000, 32'hffffffff);
        push_beat(FN_START, 32'h0, 32'h0, 32'h0);
        push_beat(3'd5, 32'hffffffff, 32'h0, 32'hffffffff);
        push_beat(3'd6, 32'h80000000, 32'h7fffffff, 32'h0);
        push_beat(3'd7, 32'h12345678, 32'hedcba987, 32'h5a5a5a5a);
        push_beat(FN_RESET, 32'h7ffff000, 32'h80001000, 32'h0);
        push_beat(FN_OBSERVE, 32'h7ffff000, 32'h80001000, 32'hffffffff);
        push_beat(FN_OBSERVE, 32'h7ffff000, 32'h80001000, 32'd5);
        push_beat(FN_OBSERVE, 32'h7ffff800, 32'h80000800, 32'd10);
        push_beat(FN_OBSERVE, 32'h7fffff00, 32'h80000100, 32'd10);
        push_beat(FN_START, 32'h0, 32'h0, 32'h0);
        push_beat(FN_ADVANCE, 32'h7fffff00, 32'h80000100, 32'd29);
        push_beat(FN_ADVANCE, 32'h7fffff00, 32'h80000100, 32'd1);
        push_beat(FN_ADVANCE, 32'h7fffff00, 32'h80000100, 32'hffffffff);
        push_beat(FN_RESET, 32'h0, 32'h0, 32'h0);
        push_beat(FN_OBSERVE, 32'h0, 32'h0, 32'd50);
        push_beat(FN_OBSERVE, 32'h0, 32'h0, 32'd50);
        push_beat(FN_OBSERVE, 32'h80000000, 32'h7fffffff, 32'd8);
        push_beat(FN_START, 32'h0, 32'h0, 32'h0);
        push_beat(FN_OBSERVE, 32'h0, 32'h0, 32'd8);
        push_beat(FN_ADVANCE, 32'h0, 32'h0, 32'd45);
        push_beat(FN_CANCEL, 32'h55555555, 32'haaaaaaaa, 32'h0);
        drain();

        // zero combine window, zero tick limit, then limit lowered mid-coast
        write_register(REG_COMBINE, 16'd0);
        write_register(REG_MAX_TICK, 16'd0);
        drag_and_fling();
        drag_and_fling();
        drain();
        write_register(REG_MAX_TICK, 16'd40);
        write_register(REG_STOP_SP, 16'd0);
        write_register(REG_DECAY, 16'd255);
        push_beat(FN_RESET, 32'd0, 32'd0, 32'd0);
        push_beat(FN_OBSERVE, 32'd3000, 32'd0, 32'd10);
        push_beat(FN_START, 32'd0, 32'd0, 32'd0);
        push_beat(FN_ADVANCE, 32'd0, 32'd0, 32'd300);
        drain();
        write_register(REG_MAX_TICK, 16'd3);
        push_beat(FN_ADVANCE, 32'd0, 32'd0, 32'd100);
        push_beat(FN_ADVANCE, 32'd0, 32'd0, 32'd100);
        drain();

        // random phases under varied settings
        for (ph = 0; ph < 9; ph++)
        begin
            if (ph == 0)
                random_settings(1'b1);
            else if (ph == 1)
            begin
                write_register(REG_COMBINE, 16'd1);
                write_register(REG_HIST_GAP, 16'd0);
                write_register(REG_REL_IDLE, 16'd254);
                write_register(REG_START_SP, 16'd0);
                write_register(REG_MAX_SP, 16'd1);
                write_register(REG_STOP_SP, 16'd0);
                write_register(REG_DECAY, 16'd0);
                write_register(REG_MAX_TICK, 16'd1);
            end
            else if (ph == 2)
            begin
                write_register(REG_COMBINE, 16'd8);
                write_register(REG_HIST_GAP, 16'd120);
                write_register(REG_REL_IDLE, 16'd80);
                write_register(REG_START_SP, 16'd512);
                write_register(REG_MAX_SP, 16'd3584);
                write_register(REG_STOP_SP, 16'd128);
                write_register(REG_DECAY, 16'd208);
                write_register(REG_MAX_TICK, 16'd12);
            end
            else
                random_settings(1'b0);
            quiet_mode = (ph == 4);
            if (ph == 5)
                hold_armed = 1'b1;
            random_phase(150);
            drain();
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
